/* src/aea_pkg.sv */
// ----------------------------------------------------------------------------
// aea_pkg
// Shared types, constants and the exp2 table builder for the auto exposure
// adaptation block.
// ----------------------------------------------------------------------------
package aea_pkg;

   localparam int DATA_W     = 24;
   localparam int RATE_W     = 16;
   localparam int DT_W       = 16;
   localparam int EV_W       = 14;
   localparam int DIVIDEND_W = 40;
   localparam int MC_W       = 32;
   localparam int MP_W       = 17;
   localparam int PROD_W     = MC_W + MP_W;
   localparam int APB_AW     = 5;
   localparam int APB_DW     = 32;

   localparam int EXP_TABLE_BITS_DEF = 6;
   localparam int EXP_ROM_DEPTH      = 1025;
   localparam int EXP_ROM_AW         = 11;

   localparam logic [MP_W-1:0]   LOG2E_Q16 = 17'd94548;
   localparam logic [MP_W-1:0]   ONE_Q16   = 17'd65536;
   localparam logic [DATA_W-1:0] LUM_FLOOR = 24'd7;
   localparam logic [DATA_W-1:0] MAX24     = 24'hFFFFFF;

   localparam logic              RST_AUTO_MODE    = 1'b1;
   localparam logic [EV_W-1:0]   RST_MANUAL_EV    = '0;
   localparam logic [DATA_W-1:0] RST_KEY_VALUE    = 24'd11796;
   localparam logic [DATA_W-1:0] RST_MIN_EXPOSURE = 24'd655;
   localparam logic [DATA_W-1:0] RST_MAX_EXPOSURE = 24'd4194304;
   localparam logic [RATE_W-1:0] RST_BRIGHT_RATE  = 16'd12288;
   localparam logic [RATE_W-1:0] RST_DARK_RATE    = 16'd4096;
   localparam logic [DATA_W-1:0] RST_SMOOTHED     = 24'd65536;

   typedef enum logic [2:0] {
      CSR_AUTO_MODE    = 3'd0,
      CSR_MANUAL_EV    = 3'd1,
      CSR_KEY_VALUE    = 3'd2,
      CSR_MIN_EXPOSURE = 3'd3,
      CSR_MAX_EXPOSURE = 3'd4,
      CSR_BRIGHT_RATE  = 3'd5,
      CSR_DARK_RATE    = 3'd6
   } csr_idx_type;

   typedef struct packed {
      logic              auto_mode;
      logic [EV_W-1:0]   manual_ev;
      logic [DATA_W-1:0] key_value;
      logic [DATA_W-1:0] min_exposure;
      logic [DATA_W-1:0] max_exposure;
      logic [RATE_W-1:0] bright_rate;
      logic [RATE_W-1:0] dark_rate;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_CLAMP,
      ST_MUL_RT,
      ST_MUL_LOG,
      ST_EXP_PREP,
      ST_MUL_INTERP,
      ST_EXP_FIN,
      ST_MUL_STEP,
      ST_DONE
   } state_type;

   typedef logic [31:0] exp_rom_type [0:EXP_ROM_DEPTH-1];

   function automatic logic [63:0] int_sqrt64(input logic [63:0] v_arg);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bit_v;
      v     = v_arg;
      res   = '0;
      bit_v = 64'd1 << 62;
      for (int j = 0; j < 32; j++) begin
         if (bit_v > v) bit_v = bit_v >> 2;
      end
      for (int j = 0; j < 32; j++) begin
         if (bit_v != '0) begin
            if (v >= res + bit_v) begin
               v   = v - (res + bit_v);
               res = (res >> 1) + bit_v;
            end else begin
               res = res >> 1;
            end
            bit_v = bit_v >> 2;
         end
      end
      return res;
   endfunction

   // entries hold 2^(k/2^tb) in Q2.30
   function automatic exp_rom_type build_exp_rom(input int tb);
      exp_rom_type rom;
      logic [63:0] r;
      logic [63:0] prod;
      for (int k = 0; k < EXP_ROM_DEPTH; k++) rom[k] = '0;
      r = 64'd2 << 30;
      for (int k = 0; k < tb; k++) r = int_sqrt64(r << 30);
      rom[0] = 32'd1 << 30;
      for (int k = 1; k <= (1 << tb); k++) begin
         prod   = ({32'd0, rom[k-1]} * r + (64'd1 << 29)) >> 30;
         rom[k] = prod[31:0];
      end
      return rom;
   endfunction

endpackage

/* src/aea_csr.sv */
// ----------------------------------------------------------------------------
// aea_csr
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module aea_csr
   import aea_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [APB_AW-1:0] paddr,
   input  logic [APB_DW-1:0] pwdata,
   output logic [APB_DW-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   csr_idx_type idx;
   logic        wr_en;

   assign pready = 1'b1;
   assign idx    = csr_idx_type'(paddr[4:2]);
   assign wr_en  = psel && penable && pwrite;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            CSR_AUTO_MODE:    cfg_in.auto_mode    = pwdata[0];
            CSR_MANUAL_EV:    cfg_in.manual_ev    = pwdata[EV_W-1:0];
            CSR_KEY_VALUE:    cfg_in.key_value    = pwdata[DATA_W-1:0];
            CSR_MIN_EXPOSURE: cfg_in.min_exposure = pwdata[DATA_W-1:0];
            CSR_MAX_EXPOSURE: cfg_in.max_exposure = pwdata[DATA_W-1:0];
            CSR_BRIGHT_RATE:  cfg_in.bright_rate  = pwdata[RATE_W-1:0];
            CSR_DARK_RATE:    cfg_in.dark_rate    = pwdata[RATE_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         CSR_AUTO_MODE:    prdata = {31'd0, cfg_ff.auto_mode};
         CSR_MANUAL_EV:    prdata = {18'd0, cfg_ff.manual_ev};
         CSR_KEY_VALUE:    prdata = {8'd0, cfg_ff.key_value};
         CSR_MIN_EXPOSURE: prdata = {8'd0, cfg_ff.min_exposure};
         CSR_MAX_EXPOSURE: prdata = {8'd0, cfg_ff.max_exposure};
         CSR_BRIGHT_RATE:  prdata = {16'd0, cfg_ff.bright_rate};
         CSR_DARK_RATE:    prdata = {16'd0, cfg_ff.dark_rate};
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.auto_mode    <= RST_AUTO_MODE;
         cfg_ff.manual_ev    <= RST_MANUAL_EV;
         cfg_ff.key_value    <= RST_KEY_VALUE;
         cfg_ff.min_exposure <= RST_MIN_EXPOSURE;
         cfg_ff.max_exposure <= RST_MAX_EXPOSURE;
         cfg_ff.bright_rate  <= RST_BRIGHT_RATE;
         cfg_ff.dark_rate    <= RST_DARK_RATE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* src/aea_div.sv */
// ----------------------------------------------------------------------------
// aea_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module aea_div
   import aea_pkg::*;
#(
   parameter int DIVIDEND_BITS = DIVIDEND_W,
   parameter int DIVISOR_BITS  = DATA_W
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DIVIDEND_BITS-1:0] dividend,
   input  logic [DIVISOR_BITS-1:0]  divisor,
   output logic [DIVIDEND_BITS-1:0] quotient,
   output logic                     busy,
   output logic                     done
);

   localparam int CNT_W = $clog2(DIVIDEND_BITS + 1);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(DIVIDEND_BITS - 1);

   logic [DIVIDEND_BITS-1:0] quo_ff, quo_in;
   logic [DIVISOR_BITS-1:0]  rem_ff, rem_in;
   logic [DIVISOR_BITS-1:0]  dvs_ff, dvs_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [DIVISOR_BITS:0]    trial;
   logic                     fits;

   // shift the next dividend bit into the partial remainder
   assign trial = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? DIVISOR_BITS'(trial - {1'b0, dvs_ff}) : trial[DIVISOR_BITS-1:0];
         quo_in = {quo_ff[DIVIDEND_BITS-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = quo_ff;
   assign busy     = busy_ff;
   assign done     = done_ff;

endmodule

/* src/aea_mul.sv */
// ----------------------------------------------------------------------------
// aea_mul
// Shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module aea_mul
   import aea_pkg::*;
#(
   parameter int MCAND_BITS  = MC_W,
   parameter int MPLIER_BITS = MP_W
)
(
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [MCAND_BITS-1:0]             mcand,
   input  logic [MPLIER_BITS-1:0]            mplier,
   output logic [MCAND_BITS+MPLIER_BITS-1:0] product,
   output logic                              busy,
   output logic                              done
);

   localparam int P_W   = MCAND_BITS + MPLIER_BITS;
   localparam int CNT_W = $clog2(MPLIER_BITS + 1);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(MPLIER_BITS - 1);

   logic [P_W-1:0]        acc_ff, acc_in;
   logic [MCAND_BITS-1:0] mc_ff, mc_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [MCAND_BITS:0]   sum;

   // upper half accumulates, lower half shifts the multiplier out
   assign sum = {1'b0, acc_ff[P_W-1:MPLIER_BITS]} + (acc_ff[0] ? {1'b0, mc_ff} : '0);

   always_comb begin
      acc_in  = acc_ff;
      mc_in   = mc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = {{MCAND_BITS{1'b0}}, mplier};
         mc_in   = mcand;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = {sum, acc_ff[MPLIER_BITS-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      mc_ff  <= mc_in;
   end

   assign product = acc_ff;
   assign busy    = busy_ff;
   assign done    = done_ff;

endmodule

/* src/auto_exposure_adaptation_top.sv */
// ----------------------------------------------------------------------------
// auto_exposure_adaptation_top
// Per-frame exposure adaptation with asymmetric exponential smoothing.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    req_luminance, req_frame_time
//   rsp      out        rsp_valid/rsp_ready    rsp_exposure_out
//   csr      in/out     psel/penable/pready    paddr, pwdata, prdata
//
// auto mode passes through the idle state, the bit-serial divider, four
// shift-add multiplier passes and four further steps (clamp, table read,
// finish, output load) per transaction.
// manual mode passes through idle, table read, one multiplier pass for
// interpolation, finish and output load.
// one transaction is in flight at a time; a new one is taken while the
// previous result still waits in the output register.
// reset is synchronous and restores registers and the smoothed exposure to 1.0.
// ----------------------------------------------------------------------------
module auto_exposure_adaptation_top
   import aea_pkg::*;
#(
   parameter int EXP_TABLE_BITS = EXP_TABLE_BITS_DEF
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [DATA_W-1:0] req_luminance,
   input  logic [DT_W-1:0]   req_frame_time,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [DATA_W-1:0] rsp_exposure_out,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [APB_AW-1:0] paddr,
   input  logic [APB_DW-1:0] pwdata,
   output logic [APB_DW-1:0] prdata,
   output logic              pready
);

   localparam int REM_W = 16 - EXP_TABLE_BITS;
   localparam exp_rom_type EXP_ROM = build_exp_rom(EXP_TABLE_BITS);

   cfg_type cfg;

   state_type state_ff, state_in;

   logic [DT_W-1:0]   dt_ff, dt_in;
   logic              auto_ff, auto_in;
   logic [DATA_W-1:0] target_ff, target_in;
   logic [DATA_W-1:0] s_ff, s_in;
   logic              sat_ff, sat_in;
   logic              zero_ff, zero_in;
   logic [5:0]        sh_ff, sh_in;
   logic [15:0]       f_ff, f_in;
   logic [31:0]       base_ff, base_in;
   logic [31:0]       m_ff, m_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic                  div_start, div_busy, div_done;
   logic [DIVIDEND_W-1:0] quotient;
   logic                  mul_start, mul_busy, mul_done;
   logic [MC_W-1:0]       mul_mcand;
   logic [MP_W-1:0]       mul_mplier;
   logic [PROD_W-1:0]     product;
   logic                  rsp_load;

   logic [DATA_W-1:0] lum_fl;
   logic [DATA_W-1:0] tgt_sat, tgt_hi, tgt_cl;
   logic [RATE_W-1:0] rate_sel;

   logic [PROD_W-1:0]     zsum;
   logic [20:0]           z;
   logic [5:0]            n_stops;

   logic [5:0]            ev_ip;
   logic signed [7:0]     ev_sh;

   logic [EXP_ROM_AW-1:0] rom_idx, rom_idx1;
   logic [31:0]           rom_diff;

   logic [47:0]           rnd;
   logic [DATA_W-1:0]     e_val;
   logic [MP_W-1:0]       coef;
   logic                  up;
   logic [DATA_W-1:0]     d_val;
   logic [PROD_W-1:0]     step_sum;
   logic [DATA_W-1:0]     step_val;

   aea_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   aea_div #(
      .DIVIDEND_BITS (DIVIDEND_W),
      .DIVISOR_BITS  (DATA_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({cfg.key_value, 16'd0}),
      .divisor  (lum_fl),
      .quotient (quotient),
      .busy     (div_busy),
      .done     (div_done)
   );

   aea_mul #(
      .MCAND_BITS  (MC_W),
      .MPLIER_BITS (MP_W)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_mcand),
      .mplier  (mul_mplier),
      .product (product),
      .busy    (mul_busy),
      .done    (mul_done)
   );

   assign req_ready        = (state_ff == ST_IDLE);
   assign accept           = req_valid && req_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_exposure_out = rsp_data_ff;
   assign rsp_load         = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // target and clamp
   assign lum_fl   = (req_luminance < LUM_FLOOR) ? LUM_FLOOR : req_luminance;
   assign tgt_sat  = (|quotient[DIVIDEND_W-1:DATA_W]) ? MAX24 : quotient[DATA_W-1:0];
   assign tgt_hi   = (tgt_sat > cfg.max_exposure) ? cfg.max_exposure : tgt_sat;
   assign tgt_cl   = (tgt_hi < cfg.min_exposure) ? cfg.min_exposure : tgt_hi;
   assign rate_sel = (tgt_cl < s_ff) ? cfg.bright_rate : cfg.dark_rate;

   // z = round(rate * dt * log2e), split into whole stops and fraction
   assign zsum    = product + (PROD_W'(1) << 27);
   assign z       = zsum[48:28];
   assign n_stops = {1'b0, z[20:16]} + {5'd0, |z[15:0]};

   // manual ev: integer part is the signed top six bits
   assign ev_ip = cfg.manual_ev[EV_W-1:8];
   assign ev_sh = 8'sd14 - {{2{ev_ip[5]}}, ev_ip};

   // table lookup and interpolation
   assign rom_idx  = EXP_ROM_AW'(f_ff[15:REM_W]);
   assign rom_idx1 = rom_idx + 1'b1;
   assign rom_diff = EXP_ROM[rom_idx1] - EXP_ROM[rom_idx];

   assign rnd   = ({16'd0, m_ff} + (48'd1 << (sh_ff - 6'd1))) >> sh_ff;
   assign e_val = sat_ff  ? MAX24 :
                  zero_ff ? '0 :
                  (|rnd[47:DATA_W]) ? MAX24 : rnd[DATA_W-1:0];
   assign coef  = ONE_Q16 - e_val[MP_W-1:0];

   assign up       = (target_ff >= s_ff);
   assign d_val    = up ? (target_ff - s_ff) : (s_ff - target_ff);
   assign step_sum = product + PROD_W'(32768);
   assign step_val = step_sum[16 +: DATA_W];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = cfg.auto_mode ? ST_DIV : ST_EXP_PREP;
         end
         ST_DIV: begin
            if (div_done) state_in = ST_CLAMP;
         end
         ST_CLAMP:      state_in = ST_MUL_RT;
         ST_MUL_RT: begin
            if (mul_done) state_in = ST_MUL_LOG;
         end
         ST_MUL_LOG: begin
            if (mul_done) state_in = ST_EXP_PREP;
         end
         ST_EXP_PREP:   state_in = ST_MUL_INTERP;
         ST_MUL_INTERP: begin
            if (mul_done) state_in = ST_EXP_FIN;
         end
         ST_EXP_FIN:    state_in = auto_ff ? ST_MUL_STEP : ST_DONE;
         ST_MUL_STEP: begin
            if (mul_done) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default:       state_in = ST_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      div_start    = 1'b0;
      mul_start    = 1'b0;
      mul_mcand    = '0;
      mul_mplier   = '0;
      dt_in        = dt_ff;
      auto_in      = auto_ff;
      target_in    = target_ff;
      s_in         = s_ff;
      sat_in       = sat_ff;
      zero_in      = zero_ff;
      sh_in        = sh_ff;
      f_in         = f_ff;
      base_in      = base_ff;
      m_in         = m_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               dt_in     = req_frame_time;
               auto_in   = cfg.auto_mode;
               div_start = cfg.auto_mode;
               sat_in    = !ev_ip[5] && (ev_ip >= 6'd8);
               zero_in   = (ev_sh > 8'sd40);
               sh_in     = ev_sh[5:0];
               f_in      = {cfg.manual_ev[7:0], 8'd0};
            end
         end
         ST_CLAMP: begin
            target_in  = tgt_cl;
            mul_start  = 1'b1;
            mul_mcand  = MC_W'(rate_sel);
            mul_mplier = MP_W'(dt_ff);
         end
         ST_MUL_RT: begin
            if (mul_done) begin
               mul_start  = 1'b1;
               mul_mcand  = product[MC_W-1:0];
               mul_mplier = LOG2E_Q16;
            end
         end
         ST_MUL_LOG: begin
            if (mul_done) begin
               sat_in  = 1'b0;
               zero_in = (n_stops > 6'd26);
               sh_in   = 6'd14 + n_stops;
               f_in    = 16'd0 - z[15:0];
            end
         end
         ST_EXP_PREP: begin
            base_in    = EXP_ROM[rom_idx];
            mul_start  = 1'b1;
            mul_mcand  = rom_diff;
            mul_mplier = MP_W'(f_ff[REM_W-1:0]);
         end
         ST_MUL_INTERP: begin
            if (mul_done) m_in = base_ff + product[REM_W +: 32];
         end
         ST_EXP_FIN: begin
            if (auto_ff) begin
               mul_start  = 1'b1;
               mul_mcand  = MC_W'(d_val);
               mul_mplier = coef;
            end else begin
               s_in = e_val;
            end
         end
         ST_MUL_STEP: begin
            if (mul_done) s_in = up ? (s_ff + step_val) : (s_ff - step_val);
         end
         ST_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = s_ff;
            end
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         s_ff         <= RST_SMOOTHED;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         s_ff         <= s_in;
      end
      dt_ff       <= dt_in;
      auto_ff     <= auto_in;
      target_ff   <= target_in;
      sat_ff      <= sat_in;
      zero_ff     <= zero_in;
      sh_ff       <= sh_in;
      f_ff        <= f_in;
      base_ff     <= base_in;
      m_ff        <= m_in;
      rsp_data_ff <= rsp_data_in;
   end

   // the divider and the multiplier are never active together
   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(div_busy && mul_busy))
      else $error("divider and multiplier busy at once");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside its wait state");

   a_mul_done_state: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_MUL_RT || state_ff == ST_MUL_LOG ||
                    state_ff == ST_MUL_INTERP || state_ff == ST_MUL_STEP))
      else $error("multiplier finished outside a wait state");

   a_result_posted: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished transaction not posted to output register");

endmodule

/* tb/aea_checker.sv */
// ----------------------------------------------------------------------------
// aea_checker
// Watches the request, response and csr channels of the auto exposure block,
// keeps its own copy of the registers and the smoothed exposure, predicts
// each exposure value and compares it with the response in order.
// ----------------------------------------------------------------------------
module aea_checker
   import aea_pkg::*;
#(
   parameter int TABLE_BITS = EXP_TABLE_BITS_DEF
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [DATA_W-1:0] req_luminance,
   input  logic [DT_W-1:0]   req_frame_time,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [DATA_W-1:0] rsp_exposure_out,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic              pready,
   input  logic [APB_AW-1:0] paddr,
   input  logic [APB_DW-1:0] pwdata,
   output int                failures,
   output int                pending
);

   logic [63:0]       pow2_tbl [0:(1<<TABLE_BITS)];
   cfg_type           regs;
   logic [DATA_W-1:0] smooth_exp;
   logic [DATA_W-1:0] exposure_q [$];

   function automatic logic [63:0] isqrt_floor(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] root;
      logic [63:0] b;
      v    = v_in;
      root = '0;
      b    = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= root + b) begin
            v    = v - (root + b);
            root = (root >> 1) + b;
         end else begin
            root = root >> 1;
         end
         b = b >> 2;
      end
      return root;
   endfunction

   initial begin
      logic [63:0] ratio;
      ratio = 64'd2 << 30;
      for (int k = 0; k < TABLE_BITS; k++) ratio = isqrt_floor(ratio << 30);
      pow2_tbl[0] = 64'd1 << 30;
      for (int k = 1; k <= (1 << TABLE_BITS); k++)
         pow2_tbl[k] = (pow2_tbl[k-1] * ratio + (64'd1 << 29)) >> 30;
   end

   // 2^x for signed q.16 x, unsigned q8.16 result saturated to 24 bits
   function automatic logic [DATA_W-1:0] pow2_q16(input longint x);
      longint      ip;
      logic [63:0] f, idx, rem, m, res;
      int          sh;
      ip = x >>> 16;
      f  = x & 64'hFFFF;
      if (ip >= 8) return MAX24;
      idx = f >> (16 - TABLE_BITS);
      rem = f & ((64'd1 << (16 - TABLE_BITS)) - 1);
      m   = pow2_tbl[idx] +
            (((pow2_tbl[idx+1] - pow2_tbl[idx]) * rem) >> (16 - TABLE_BITS));
      if (14 - ip > 40) return '0;
      sh  = 14 - ip;
      res = (m + (64'd1 << (sh - 1))) >> sh;
      return (res > MAX24) ? MAX24 : res[DATA_W-1:0];
   endfunction

   function automatic logic [DATA_W-1:0] next_exposure(input logic [DATA_W-1:0] lum_in,
                                                       input logic [DT_W-1:0] dt);
      logic [63:0] lum, target, rate, z, coef, d, step;
      logic [63:0] s;
      s = smooth_exp;
      if (!regs.auto_mode) return pow2_q16(longint'($signed(regs.manual_ev)) * 256);
      lum = (lum_in < LUM_FLOOR) ? LUM_FLOOR : lum_in;
      target = ({40'd0, regs.key_value} << 16) / lum;
      if (target > MAX24) target = MAX24;
      if (target > regs.max_exposure) target = regs.max_exposure;
      if (target < regs.min_exposure) target = regs.min_exposure;
      rate = (target < s) ? regs.bright_rate : regs.dark_rate;
      z    = (rate * dt * 94548 + (64'd1 << 27)) >> 28;
      coef = 65536 - pow2_q16(-longint'(z));
      if (target >= s) begin
         d    = target - s;
         step = (d * coef + 32768) >> 16;
         s    = s + step;
      end else begin
         d    = s - target;
         step = (d * coef + 32768) >> 16;
         s    = s - step;
      end
      return s[DATA_W-1:0];
   endfunction

   always @(posedge clock) begin
      logic [DATA_W-1:0] want;
      if (reset) begin
         regs.auto_mode    <= RST_AUTO_MODE;
         regs.manual_ev    <= RST_MANUAL_EV;
         regs.key_value    <= RST_KEY_VALUE;
         regs.min_exposure <= RST_MIN_EXPOSURE;
         regs.max_exposure <= RST_MAX_EXPOSURE;
         regs.bright_rate  <= RST_BRIGHT_RATE;
         regs.dark_rate    <= RST_DARK_RATE;
         smooth_exp        <= RST_SMOOTHED;
         exposure_q.delete();
         failures          <= 0;
         pending           <= 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (csr_idx_type'(paddr[4:2]))
               CSR_AUTO_MODE:    regs.auto_mode    <= pwdata[0];
               CSR_MANUAL_EV:    regs.manual_ev    <= pwdata[EV_W-1:0];
               CSR_KEY_VALUE:    regs.key_value    <= pwdata[DATA_W-1:0];
               CSR_MIN_EXPOSURE: regs.min_exposure <= pwdata[DATA_W-1:0];
               CSR_MAX_EXPOSURE: regs.max_exposure <= pwdata[DATA_W-1:0];
               CSR_BRIGHT_RATE:  regs.bright_rate  <= pwdata[RATE_W-1:0];
               CSR_DARK_RATE:    regs.dark_rate    <= pwdata[RATE_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            want = next_exposure(req_luminance, req_frame_time);
            smooth_exp <= want;
            exposure_q.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            if (exposure_q.size() == 0) begin
               $error("exposure_out: no transaction expected, actual %0d", rsp_exposure_out);
               failures <= failures + 1;
            end else begin
               want = exposure_q.pop_front();
               if (rsp_exposure_out !== want) begin
                  $error("exposure_out: expected %0d, actual %0d", want, rsp_exposure_out);
                  failures <= failures + 1;
               end
            end
         end
         pending <= exposure_q.size();
      end
   end

endmodule

/* tb/tb_auto_exposure_adaptation_top.sv */
// ----------------------------------------------------------------------------
// tb_auto_exposure_adaptation_top
// Drives frames and csr settings into the auto exposure block with bursty
// requests and a stalling receiver; a checker beside the block predicts and
// compares every exposure value, and this module reports the verdict.
// ----------------------------------------------------------------------------
module tb_auto_exposure_adaptation_top;
   import aea_pkg::*;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [DATA_W-1:0] req_luminance = '0;
   logic [DT_W-1:0]   req_frame_time = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [DATA_W-1:0] rsp_exposure_out;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [APB_AW-1:0] paddr = '0;
   logic [APB_DW-1:0] pwdata = '0;
   logic [APB_DW-1:0] prdata;
   logic              pready;
   int                failures;
   int                pending;
   int                burst_left = 0;
   int                stall_mode = 0;
   int                stall_left = 0;

   always #1 clock = ~clock;

   auto_exposure_adaptation_top dut (.*);

   aea_checker chk (
      .clock, .reset, .req_valid, .req_ready, .req_luminance, .req_frame_time,
      .rsp_valid, .rsp_ready, .rsp_exposure_out, .psel, .penable, .pwrite,
      .pready, .paddr, .pwdata, .failures, .pending
   );

   // receiver: phases of always ready, random stalls and long stalls
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_left <= $urandom_range(10, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= ($urandom_range(0, 1) == 1);
         default: rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   task automatic csr_write(input csr_idx_type idx, input logic [APB_DW-1:0] val);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= APB_AW'(idx) << 2;
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // called right after an edge; the new transaction is driven at that edge
   task automatic send_frame(input logic [DATA_W-1:0] lum, input logic [DT_W-1:0] dt);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 20);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_luminance  <= lum;
      req_frame_time <= dt;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   function automatic logic [DATA_W-1:0] pick24();
      case ($urandom_range(0, 4))
         0:       return '0;
         1:       return MAX24;
         2:       return DATA_W'($urandom_range(0, 255));
         default: return DATA_W'($urandom());
      endcase
   endfunction

   function automatic logic [RATE_W-1:0] pick_rate();
      case ($urandom_range(0, 4))
         0:       return '0;
         1:       return 16'hFFFF;
         2:       return RATE_W'($urandom_range(1, 16384));
         default: return RATE_W'($urandom());
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] pick_lum();
      case ($urandom_range(0, 5))
         0:       return DATA_W'($urandom_range(0, 10));
         1:       return MAX24;
         2:       return DATA_W'($urandom_range(0, 65535));
         default: return DATA_W'($urandom());
      endcase
   endfunction

   function automatic logic [DT_W-1:0] pick_dt();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return 16'hFFFF;
         2:       return DT_W'($urandom_range(500, 3000));
         default: return DT_W'($urandom());
      endcase
   endfunction

   initial begin
      int ev;
      int ev_list [8];
      ev_list = '{-4096, 4096, 0, 2047, 2048, -1, -3000, 256};
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // defaults after reset: luminance floor, extremes, zero frame time
      send_frame(24'd0, 16'd1092);
      send_frame(24'd1, 16'hFFFF);
      send_frame(24'd7, 16'd0);
      send_frame(24'd8, 16'd1092);
      send_frame(MAX24, 16'hFFFF);
      send_frame(24'd65536, 16'hFFFF);
      send_frame(24'd65536, 16'hFFFF);
      send_frame(24'd65536, 16'd0);
      wait_drained();

      // manual ev: saturation, zero, negative extremes
      csr_write(CSR_AUTO_MODE, 32'd0);
      foreach (ev_list[i]) begin
         ev = ev_list[i];
         csr_write(CSR_MANUAL_EV, 32'(ev) & 32'h3FFF);
         send_frame(DATA_W'($urandom()), DT_W'($urandom()));
         wait_drained();
      end

      // inverted limits and zero key in auto mode
      csr_write(CSR_AUTO_MODE, 32'd1);
      csr_write(CSR_MIN_EXPOSURE, 32'd200000);
      csr_write(CSR_MAX_EXPOSURE, 32'd1000);
      send_frame(24'd100, 16'hFFFF);
      send_frame(MAX24, 16'd3000);
      wait_drained();
      csr_write(CSR_KEY_VALUE, 32'd0);
      csr_write(CSR_MIN_EXPOSURE, 32'd0);
      csr_write(CSR_MAX_EXPOSURE, 32'(MAX24));
      csr_write(CSR_BRIGHT_RATE, 32'hFFFF);
      csr_write(CSR_DARK_RATE, 32'd0);
      send_frame(24'd5000, 16'hFFFF);
      send_frame(24'd5000, 16'hFFFF);
      wait_drained();

      // random phases, each with fresh register settings
      for (int ph = 0; ph < 10; ph++) begin
         csr_write(CSR_AUTO_MODE, 32'($urandom_range(0, 4) != 0));
         ev = $urandom_range(0, 8192);
         csr_write(CSR_MANUAL_EV, 32'(ev - 4096) & 32'h3FFF);
         csr_write(CSR_KEY_VALUE, ($urandom_range(0, 2) == 0) ? 32'(pick24()) :
                   $urandom_range(1000, 40000));
         csr_write(CSR_MIN_EXPOSURE, ($urandom_range(0, 2) == 0) ? 32'(pick24()) :
                   $urandom_range(0, 2000));
         csr_write(CSR_MAX_EXPOSURE, ($urandom_range(0, 2) == 0) ? 32'(pick24()) :
                   $urandom_range(1 << 20, 32'(MAX24)));
         csr_write(CSR_BRIGHT_RATE, 32'(pick_rate()));
         csr_write(CSR_DARK_RATE, 32'(pick_rate()));
         repeat (40) send_frame(pick_lum(), pick_dt());
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (failures == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #4000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

/* sim.f */
src/aea_pkg.sv
src/aea_csr.sv
src/aea_div.sv
src/aea_mul.sv
src/auto_exposure_adaptation_top.sv
tb/aea_checker.sv
tb/tb_auto_exposure_adaptation_top.sv
